/* design/lcbm_pkg.sv */
// ----------------------------------------------------------------------------
// lcbm_pkg: shared types and constants of the latched CHR bank mapper
// Request/result structs, command and target codes, register selects and
// the interface between the sequencer and the remainder unit.
// ----------------------------------------------------------------------------
package lcbm_pkg;

  // Bank limits
  localparam int unsigned PrgBankMax = 16;
  localparam int unsigned ChrBankMax = 32;

  // Field widths
  localparam int unsigned AddrW     = 16;
  localparam int unsigned DataW     = 8;
  localparam int unsigned MemAddrW  = 17;
  localparam int unsigned PrgCountW = 5;
  localparam int unsigned ChrCountW = 6;
  localparam int unsigned PrgSelW   = 4;
  localparam int unsigned ChrSelW   = 5;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 6;

  // Remainder unit: dividend and remainder are 5 bits, divisor up to 32
  localparam int unsigned DvdW    = 5;
  localparam int unsigned DvsW    = 6;
  localparam int unsigned StepCnt = DvdW;
  localparam int unsigned StepW   = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PRG_COUNT   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CHR_COUNT   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RAM_PRESENT = 2'd2;

  // Register selects of a CPU write at A000-FFFF (addr bits 14..12)
  localparam logic [2:0] REG_SEL_PRG     = 3'd2;
  localparam logic [2:0] REG_SEL_LOW_FD  = 3'd3;
  localparam logic [2:0] REG_SEL_LOW_FE  = 3'd4;
  localparam logic [2:0] REG_SEL_HIGH_FD = 3'd5;
  localparam logic [2:0] REG_SEL_HIGH_FE = 3'd6;
  localparam logic [2:0] REG_SEL_MIRROR  = 3'd7;

  // PRG windows (addr bits 14..13 above 8000)
  localparam logic [1:0] WIN_8000 = 2'd0;
  localparam logic [1:0] WIN_A000 = 2'd1;
  localparam logic [1:0] WIN_C000 = 2'd2;
  localparam logic [1:0] WIN_E000 = 2'd3;

  // Latch trigger tiles: addr bits 11..3 of xFD8-xFDF and xFE8-xFEF
  localparam logic [8:0] TILE_FD = 9'h1FB;
  localparam logic [8:0] TILE_FE = 9'h1FD;

  typedef enum logic [1:0] {
    CMD_CPU_RD = 2'd0,
    CMD_CPU_WR = 2'd1,
    CMD_PPU_RD = 2'd2,
    CMD_PPU_WR = 2'd3
  } lcbm_cmd_e;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_RAM  = 2'd1,
    TGT_PRG  = 2'd2,
    TGT_CHR  = 2'd3
  } lcbm_tgt_e;

  typedef struct packed {
    lcbm_cmd_e          cmd;
    logic [AddrW-1:0]   addr;
    logic [DataW-1:0]   wdata;
  } lcbm_req_t;

  typedef struct packed {
    lcbm_tgt_e             mem_target;
    logic [MemAddrW-1:0]   mem_addr;
    logic                  mem_write;
    logic                  handled;
    logic                  mirror_h;
  } lcbm_rsp_t;

  // Sequencer to remainder unit
  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dividend;
    logic [DvsW-1:0] divisor;
  } lcbm_mod_req_t;

  // Remainder unit to sequencer
  typedef struct packed {
    logic            done;
    logic [DvdW-1:0] rem;
  } lcbm_mod_rsp_t;

endpackage

/* design/lcbm_mod_unit.sv */
// ----------------------------------------------------------------------------
// lcbm_mod_unit: bit-serial bank remainder
// Restoring remainder, one dividend bit per cycle through one shared
// compare-and-subtract; done pulses for one cycle with the remainder.
// ----------------------------------------------------------------------------
module lcbm_mod_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lcbm_pkg::lcbm_mod_req_t req_i,
  output lcbm_pkg::lcbm_mod_rsp_t rsp_o
);
  import lcbm_pkg::*;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic [DvdW-1:0] dvd_q, dvd_d;
  logic [DvsW-1:0] dvs_q, dvs_d;
  logic [DvdW-1:0] rem_q, rem_d;

  // Shared compare and subtract: partial remainder with next dividend bit
  logic [DvsW-1:0] trial;
  logic            trial_ge;
  logic [DvsW-1:0] trial_sub;

  assign trial     = {rem_q, dvd_q[DvdW-1]};
  assign trial_ge  = (trial >= dvs_q);
  assign trial_sub = trial - dvs_q;

  // Step sequencing
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = trial_ge ? trial_sub[DvdW-1:0] : trial[DvdW-1:0];
      dvd_d = {dvd_q[DvdW-2:0], 1'b0};
      cnt_d = cnt_q + StepW'(1);
      if (cnt_q == StepW'(StepCnt - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

  // A new reduction never starts over a running one
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("remainder unit restarted while busy");

  // The remainder is below the divisor
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ({1'b0, rem_q} < dvs_q))
    else $error("remainder not below divisor");

  // Done comes in the cycle after the last step
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("done without a preceding step");

endmodule

/* design/latched_chr_bank_mapper.sv */
// ----------------------------------------------------------------------------
// latched_chr_bank_mapper: cartridge address mapper with latched CHR banks
// A PRG ROM read or a pattern access has its bank reduced by the 5-step
// bit-serial bank remainder before its result is formed; others skip it.
// One request is held at a time, taken once the last result is registered;
// a finished result waits in the output register while the next is accepted.
// Reset: bank registers zero, both latches FE, vertical mirroring, counts
// 16 PRG / 32 CHR banks with work RAM present. No clearing pass.
// ----------------------------------------------------------------------------
module latched_chr_bank_mapper (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration port
  input  logic                             cfg_we_i,
  input  logic [lcbm_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [lcbm_pkg::CfgDataW-1:0]    cfg_wdata_i,
  // request channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  lcbm_pkg::lcbm_req_t              in_req_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output lcbm_pkg::lcbm_rsp_t              out_rsp_o
);
  import lcbm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  // Configuration registers
  logic [PrgCountW-1:0] prg_count_q;
  logic [ChrCountW-1:0] chr_count_q;
  logic                 ram_present_q;

  // Mapper state
  logic [PrgSelW-1:0] prg_select_q, prg_select_d;
  logic [ChrSelW-1:0] chr_low_fd_q, chr_low_fd_d;
  logic [ChrSelW-1:0] chr_low_fe_q, chr_low_fe_d;
  logic [ChrSelW-1:0] chr_high_fd_q, chr_high_fd_d;
  logic [ChrSelW-1:0] chr_high_fe_q, chr_high_fe_d;
  logic               latch_low_q, latch_low_d;
  logic               latch_high_q, latch_high_d;
  logic               mirror_q, mirror_d;

  // Sequencer and held request
  logic [1:0]      state_q, state_d;
  lcbm_req_t       item_q;
  logic [DvdW-1:0] bank_q;

  // Output register
  logic      out_valid_q;
  lcbm_rsp_t out_rsp_q;
  lcbm_rsp_t res;

  lcbm_mod_req_t mod_req;
  lcbm_mod_rsp_t mod_rsp;

  logic                 in_fire, fin_fire;
  logic [PrgCountW-1:0] pcount;
  logic [ChrCountW-1:0] ccount;
  logic                 need_prg, need_chr;
  logic [DvdW-1:0]      prg_win_bank, chr_bank;
  logic                 ram_win, chr_win;

  // Clamped bank counts
  assign pcount = (prg_count_q > PrgCountW'(PrgBankMax)) ? PrgCountW'(PrgBankMax) : prg_count_q;
  assign ccount = (chr_count_q > ChrCountW'(ChrBankMax)) ? ChrCountW'(ChrBankMax) : chr_count_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;

  // Bank to reduce, picked at accept; fixed banks wrap, low bits suffice
  always_comb begin
    unique case (in_req_i.addr[14:13])
      WIN_8000: prg_win_bank = {1'b0, prg_select_q};
      WIN_A000: prg_win_bank = pcount - PrgCountW'(3);
      WIN_C000: prg_win_bank = pcount - PrgCountW'(2);
      WIN_E000: prg_win_bank = pcount - PrgCountW'(1);
      default:  prg_win_bank = '0;
    endcase
  end

  assign chr_bank = in_req_i.addr[12] ? (latch_high_q ? chr_high_fe_q : chr_high_fd_q)
                                      : (latch_low_q  ? chr_low_fe_q  : chr_low_fd_q);

  assign need_prg = (in_req_i.cmd == CMD_CPU_RD) && in_req_i.addr[15] && (pcount != '0);
  assign need_chr = ((in_req_i.cmd == CMD_PPU_RD) || (in_req_i.cmd == CMD_PPU_WR)) &&
                    (in_req_i.addr[15:13] == 3'b000) && (ccount != '0);

  assign mod_req.start    = in_fire && (need_prg || need_chr);
  assign mod_req.dividend = need_prg ? prg_win_bank : chr_bank;
  assign mod_req.divisor  = need_prg ? {1'b0, pcount} : ccount;

  lcbm_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  // Sequencer
  assign fin_fire = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) begin
        state_d = mod_req.start ? ST_DIV : ST_FIN;
      end
      ST_DIV: if (mod_rsp.done) begin
        state_d = ST_FIN;
      end
      ST_FIN: if (fin_fire) begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Translation and register updates of the held request
  assign ram_win = (item_q.addr[15:13] == 3'b011);
  assign chr_win = (item_q.addr[15:13] == 3'b000) && (ccount != '0);

  always_comb begin
    res            = '0;
    res.mem_target = TGT_NONE;
    res.mirror_h   = mirror_q;
    prg_select_d  = prg_select_q;
    chr_low_fd_d  = chr_low_fd_q;
    chr_low_fe_d  = chr_low_fe_q;
    chr_high_fd_d = chr_high_fd_q;
    chr_high_fe_d = chr_high_fe_q;
    latch_low_d   = latch_low_q;
    latch_high_d  = latch_high_q;
    mirror_d      = mirror_q;
    unique case (item_q.cmd)
      CMD_CPU_RD: begin
        if (ram_win) begin
          res.handled = 1'b1;
          if (ram_present_q) begin
            res.mem_target = TGT_RAM;
            res.mem_addr   = {4'd0, item_q.addr[12:0]};
          end
        end else if (item_q.addr[15]) begin
          res.handled = 1'b1;
          if (pcount != '0) begin
            res.mem_target = TGT_PRG;
            res.mem_addr   = {bank_q[PrgSelW-1:0], item_q.addr[12:0]};
          end
        end
      end
      CMD_CPU_WR: begin
        if (ram_win) begin
          if (ram_present_q) begin
            res.mem_target = TGT_RAM;
            res.mem_addr   = {4'd0, item_q.addr[12:0]};
            res.mem_write  = 1'b1;
          end
        end else if (item_q.addr[15] && (item_q.addr[14:13] != WIN_8000)) begin
          // bank and mirroring register writes
          unique case (item_q.addr[14:12])
            REG_SEL_PRG:     prg_select_d  = item_q.wdata[PrgSelW-1:0];
            REG_SEL_LOW_FD:  chr_low_fd_d  = item_q.wdata[ChrSelW-1:0];
            REG_SEL_LOW_FE:  chr_low_fe_d  = item_q.wdata[ChrSelW-1:0];
            REG_SEL_HIGH_FD: chr_high_fd_d = item_q.wdata[ChrSelW-1:0];
            REG_SEL_HIGH_FE: chr_high_fe_d = item_q.wdata[ChrSelW-1:0];
            REG_SEL_MIRROR: begin
              mirror_d     = item_q.wdata[0];
              res.mirror_h = item_q.wdata[0];
            end
            default: ;
          endcase
        end
      end
      CMD_PPU_RD, CMD_PPU_WR: begin
        if (chr_win) begin
          res.mem_target = TGT_CHR;
          res.mem_addr   = {bank_q, item_q.addr[11:0]};
          if (item_q.cmd == CMD_PPU_RD) begin
            res.handled = 1'b1;
            // latch trigger tiles, applied after translation
            if (item_q.addr[11:3] == TILE_FD) begin
              if (item_q.addr[12]) latch_high_d = 1'b0;
              else                 latch_low_d  = 1'b0;
            end else if (item_q.addr[11:3] == TILE_FE) begin
              if (item_q.addr[12]) latch_high_d = 1'b1;
              else                 latch_low_d  = 1'b1;
            end
          end else begin
            res.mem_write = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Control and mapper state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_q   <= 1'b0;
      prg_count_q   <= PrgCountW'(PrgBankMax);
      chr_count_q   <= ChrCountW'(ChrBankMax);
      ram_present_q <= 1'b1;
      prg_select_q  <= '0;
      chr_low_fd_q  <= '0;
      chr_low_fe_q  <= '0;
      chr_high_fd_q <= '0;
      chr_high_fe_q <= '0;
      latch_low_q   <= 1'b1;
      latch_high_q  <= 1'b1;
      mirror_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_PRG_COUNT:   prg_count_q   <= cfg_wdata_i[PrgCountW-1:0];
          CFG_CHR_COUNT:   chr_count_q   <= cfg_wdata_i[ChrCountW-1:0];
          CFG_RAM_PRESENT: ram_present_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (fin_fire) begin
        prg_select_q  <= prg_select_d;
        chr_low_fd_q  <= chr_low_fd_d;
        chr_low_fe_q  <= chr_low_fe_d;
        chr_high_fd_q <= chr_high_fd_d;
        chr_high_fe_q <= chr_high_fe_d;
        latch_low_q   <= latch_low_d;
        latch_high_q  <= latch_high_d;
        mirror_q      <= mirror_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_req_i;
    end
    if ((state_q == ST_DIV) && mod_rsp.done) begin
      bank_q <= mod_rsp.rem;
    end
    if (fin_fire) begin
      out_rsp_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // No target means no offset and no write
  a_none_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.mem_target == TGT_NONE) |->
      (out_rsp_o.mem_addr == '0) && !out_rsp_o.mem_write)
    else $error("idle target carries address or write");

  // Writes are never claimed as reads
  a_write_unclaimed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_rsp_o.mem_write && out_rsp_o.handled))
    else $error("write flagged as handled");

  // A request needing a bank reduction waits for the remainder unit
  a_start_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_req.start |=> (state_q == ST_DIV))
    else $error("reduction started but sequencer not waiting");

  // Remainder results arrive only while the sequencer waits for one
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_rsp.done |-> (state_q == ST_DIV))
    else $error("remainder result outside wait state");

endmodule
